@@ design/lvm_pkg.sv @@
// ----------------------------------------------------------------------------
// lvm_pkg
// Shared constants and rounding helpers for the look-at view matrix block.
// ----------------------------------------------------------------------------
package lvm_pkg;

  localparam int AXIS_FRAC = 30;

  // Shift right by AXIS_FRAC, rounding half away from zero.
  function automatic logic signed [34:0] rnd_shr(input logic signed [63:0] x);
    logic [63:0] mag;
    logic [63:0] sum;
    logic [34:0] q;
    mag = x[63] ? 64'(-x) : 64'(x);
    sum = mag + (64'd1 << (AXIS_FRAC - 1));
    q = {1'b0, sum[63:AXIS_FRAC]};
    rnd_shr = x[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
    logic signed [31:0] r;
    if (x > 35'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -35'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    sat32 = r;
  endfunction

  function automatic logic signed [31:0] clamp_axis(input logic signed [34:0] x);
    logic signed [31:0] r;
    if (x > 35'sh0_4000_0000) begin
      r = 32'sh4000_0000;
    end else if (x < -35'sh0_4000_0000) begin
      r = -32'sh4000_0000;
    end else begin
      r = x[31:0];
    end
    clamp_axis = r;
  endfunction

endpackage

@@ design/lvm_norm.sv @@
// ----------------------------------------------------------------------------
// lvm_norm
// Pipelined 3-vector normalizer: common-exponent scaling, digit-serial
// square root and restoring division, one stage per result bit.
// ----------------------------------------------------------------------------
module lvm_norm #(
  parameter int IW = 33,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [IW-1:0] in_vec [0:2],
  input  logic [SW-1:0]        in_side,
  output logic                 out_vld,
  output logic signed [31:0]   out_vec [0:2],
  output logic [SW-1:0]        out_side
);

  localparam int AF  = lvm_pkg::AXIS_FRAC;
  localparam int BW  = $clog2(IW + 1);
  localparam int SQW = 2 * AF + 2;
  localparam int RW  = SQW + 1;
  localparam int LW  = AF + 1;
  localparam int NSQ = AF + 2;
  localparam int NDV = AF + 1;
  localparam int CW  = SW + 4 + 3 * AF;

  // stage 1: sign and magnitude
  logic [IW-1:0] mag1_r [0:2];
  logic [2:0]    neg1_r;
  logic [SW-1:0] side1_r;
  logic          vld1_r;
  // stage 2: bit length of largest magnitude
  logic [BW-1:0] bl2_r;
  logic [IW-1:0] mag2_r [0:2];
  logic [2:0]    neg2_r;
  logic [SW-1:0] side2_r;
  logic          vld2_r;
  // stage 3: scaled magnitudes
  logic [AF-1:0] nm3_r [0:2];
  logic          zero3_r;
  logic [2:0]    neg3_r;
  logic [SW-1:0] side3_r;
  logic          vld3_r;
  // stage 4: squares
  logic [2*AF-1:0] sq4_r [0:2];
  logic [AF-1:0]   nm4_r [0:2];
  logic            zero4_r;
  logic [2:0]      neg4_r;
  logic [SW-1:0]   side4_r;
  logic            vld4_r;
  // square root pipeline
  logic [SQW-1:0] sq_s_r   [0:NSQ];
  logic [RW-1:0]  sq_res_r [0:NSQ];
  logic [CW-1:0]  car_r    [0:NSQ];
  logic           sqv_r    [0:NSQ];
  // division pipeline
  logic [LW-1:0]    dv_rem_r [0:NDV][0:2];
  logic [AF:0]      dv_lo_r  [0:NDV][0:2];
  logic [LW-1:0]    dv_q_r   [0:NDV][0:2];
  logic [LW-1:0]    dv_len_r [0:NDV];
  logic [SW+3:0]    dv_ctl_r [0:NDV];
  logic             dvv_r    [0:NDV];
  // output
  logic signed [31:0] o_vec_r [0:2];
  logic [SW-1:0]      o_side_r;
  logic               o_vld_r;

  logic [IW-1:0]    or_mag;
  logic [BW-1:0]    bl_nxt;
  logic [IW+AF-1:0] ext [0:2];
  logic [LW-1:0]    len;
  logic [2*AF:0]    num [0:2];

  always_comb begin
    or_mag = mag1_r[0] | mag1_r[1] | mag1_r[2];
    bl_nxt = '0;
    for (int i = 0; i < IW; i++) begin
      if (or_mag[i]) begin
        bl_nxt = BW'(i + 1);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ext[c] = {mag2_r[c], {AF{1'b0}}} >> bl2_r;
    end
  end

  assign len = sq_res_r[NSQ][LW-1:0];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num[c] = {1'b0, car_r[NSQ][c*AF +: AF], {AF{1'b0}}} + (2*AF+1)'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      sqv_r[0] <= 1'b0;
      dvv_r[0] <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      sqv_r[0] <= vld4_r;
      dvv_r[0] <= sqv_r[NSQ];
      o_vld_r <= dvv_r[NDV];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        neg1_r[c] <= in_vec[c][IW-1];
        mag1_r[c] <= in_vec[c][IW-1] ? IW'(-in_vec[c]) : IW'(in_vec[c]);
        mag2_r[c] <= mag1_r[c];
        nm3_r[c]  <= ext[c][AF-1:0];
        sq4_r[c]  <= nm3_r[c] * nm3_r[c];
        nm4_r[c]  <= nm3_r[c];
      end
      side1_r <= in_side;
      bl2_r   <= bl_nxt;
      neg2_r  <= neg1_r;
      side2_r <= side1_r;
      zero3_r <= (bl2_r == '0);
      neg3_r  <= neg2_r;
      side3_r <= side2_r;
      zero4_r <= zero3_r;
      neg4_r  <= neg3_r;
      side4_r <= side3_r;
      sq_s_r[0]   <= SQW'(sq4_r[0]) + SQW'(sq4_r[1]) + SQW'(sq4_r[2]);
      sq_res_r[0] <= '0;
      car_r[0]    <= {side4_r, neg4_r, zero4_r, nm4_r[2], nm4_r[1], nm4_r[0]};
      for (int c = 0; c < 3; c++) begin
        dv_rem_r[0][c] <= LW'(num[c][2*AF:AF+1]);
        dv_lo_r[0][c]  <= num[c][AF:0];
        dv_q_r[0][c]   <= '0;
      end
      dv_len_r[0] <= len;
      dv_ctl_r[0] <= car_r[NSQ][CW-1:3*AF];
      for (int c = 0; c < 3; c++) begin
        if (dv_ctl_r[NDV][0]) begin
          o_vec_r[c] <= '0;
        end else if (dv_ctl_r[NDV][c+1]) begin
          o_vec_r[c] <= -$signed(32'(dv_q_r[NDV][c]));
        end else begin
          o_vec_r[c] <= $signed(32'(dv_q_r[NDV][c]));
        end
      end
      o_side_r <= dv_ctl_r[NDV][SW+3:4];
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    localparam logic [RW-1:0] BIT = RW'(1) << (SQW - 2 * k);
    logic [RW-1:0] trial;
    logic          take;
    assign trial = sq_res_r[k] + BIT;
    assign take  = ({1'b0, sq_s_r[k]} >= trial);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sqv_r[k+1] <= 1'b0;
      end else if (en) begin
        sqv_r[k+1] <= sqv_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_s_r[k+1]   <= take ? SQW'({1'b0, sq_s_r[k]} - trial) : sq_s_r[k];
        sq_res_r[k+1] <= take ? ((sq_res_r[k] >> 1) + BIT) : (sq_res_r[k] >> 1);
        car_r[k+1]    <= car_r[k];
      end
    end
  end

  for (genvar j = 0; j < NDV; j++) begin : g_div
    logic [LW:0] cand [0:2];
    logic [LW:0] diff [0:2];
    logic [2:0]  ge;
    always_comb begin
      for (int c = 0; c < 3; c++) begin
        cand[c] = {dv_rem_r[j][c], dv_lo_r[j][c][AF]};
        diff[c] = cand[c] - {1'b0, dv_len_r[j]};
        ge[c]   = (cand[c] >= {1'b0, dv_len_r[j]});
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvv_r[j+1] <= 1'b0;
      end else if (en) begin
        dvv_r[j+1] <= dvv_r[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          dv_rem_r[j+1][c] <= ge[c] ? diff[c][LW-1:0] : cand[c][LW-1:0];
          dv_lo_r[j+1][c]  <= dv_lo_r[j][c] << 1;
          dv_q_r[j+1][c]   <= {dv_q_r[j][c][LW-2:0], ge[c]};
        end
        dv_len_r[j+1] <= dv_len_r[j];
        dv_ctl_r[j+1] <= dv_ctl_r[j];
      end
    end
  end

  assign out_vld  = o_vld_r;
  assign out_vec  = o_vec_r;
  assign out_side = o_side_r;

endmodule

@@ design/look_at_view_matrix_top.sv @@
// ----------------------------------------------------------------------------
// look_at_view_matrix_top
// Look-at camera view matrix (row-vector form), fully pipelined.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): eye, target and up hint, signed Q16.16.
// Output channel (out_valid/out_ready): right, up and forward axes in Q2.30
// and the three translations, saturated Q16.16.
// Each transaction produces exactly one result transaction.
// The path holds two normalizers of 70 stages each (one stage per square root
// digit and one per quotient bit), plus cross product and dot product stages.
// Throughput: one transaction per cycle while the receiver does not stall.
// Reset: clears all valid bits; in_ready is high right after reset.
// Receiver stall: while out_valid is high and out_ready low, the whole
// pipeline holds and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module look_at_view_matrix_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_eye_x,
  input  logic signed [31:0] in_eye_y,
  input  logic signed [31:0] in_eye_z,
  input  logic signed [31:0] in_target_x,
  input  logic signed [31:0] in_target_y,
  input  logic signed [31:0] in_target_z,
  input  logic signed [31:0] in_up_x,
  input  logic signed [31:0] in_up_y,
  input  logic signed [31:0] in_up_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_right_x,
  output logic signed [31:0] out_right_y,
  output logic signed [31:0] out_right_z,
  output logic signed [31:0] out_upaxis_x,
  output logic signed [31:0] out_upaxis_y,
  output logic signed [31:0] out_upaxis_z,
  output logic signed [31:0] out_fwd_x,
  output logic signed [31:0] out_fwd_y,
  output logic signed [31:0] out_fwd_z,
  output logic signed [31:0] out_trans_x,
  output logic signed [31:0] out_trans_y,
  output logic signed [31:0] out_trans_z
);

  logic en;

  // input stage
  logic signed [32:0] d1_r   [0:2];
  logic signed [31:0] eye1_r [0:2];
  logic signed [31:0] up1_r  [0:2];
  logic               v1_r;

  // forward normalizer
  logic               nv1_vld;
  logic signed [31:0] nv1_vec [0:2];
  logic [191:0]       nv1_side;
  logic signed [31:0] eye_a  [0:2];
  logic signed [31:0] up_a   [0:2];

  // up x n
  logic signed [63:0] pc_r    [0:5];
  logic signed [31:0] n_c1_r  [0:2];
  logic signed [31:0] e_c1_r  [0:2];
  logic               vc1_r;
  logic signed [63:0] cc_r    [0:2];
  logic signed [31:0] n_c2_r  [0:2];
  logic signed [31:0] e_c2_r  [0:2];
  logic               vc2_r;

  // right normalizer
  logic               nv2_vld;
  logic signed [31:0] nv2_vec [0:2];
  logic [191:0]       nv2_side;
  logic signed [31:0] eye_b  [0:2];
  logic signed [31:0] n_b    [0:2];

  // post stages
  logic signed [63:0] pm_r   [0:5];
  logic signed [63:0] eu_r   [0:2];
  logic signed [63:0] ew_r   [0:2];
  logic signed [31:0] u_p1_r [0:2];
  logic signed [31:0] n_p1_r [0:2];
  logic signed [31:0] e_p1_r [0:2];
  logic               vp1_r;
  logic signed [63:0] c2_r   [0:2];
  logic signed [63:0] su_r;
  logic signed [63:0] sn_r;
  logic signed [31:0] u_p2_r [0:2];
  logic signed [31:0] n_p2_r [0:2];
  logic signed [31:0] e_p2_r [0:2];
  logic               vp2_r;
  logic signed [31:0] v_p3_r [0:2];
  logic signed [31:0] u_p3_r [0:2];
  logic signed [31:0] n_p3_r [0:2];
  logic signed [31:0] e_p3_r [0:2];
  logic signed [31:0] tx_p3_r;
  logic signed [31:0] tz_p3_r;
  logic               vp3_r;
  logic signed [63:0] ev_r   [0:2];
  logic signed [31:0] v_p4_r [0:2];
  logic signed [31:0] u_p4_r [0:2];
  logic signed [31:0] n_p4_r [0:2];
  logic signed [31:0] tx_p4_r;
  logic signed [31:0] tz_p4_r;
  logic               vp4_r;
  logic signed [63:0] sv_r;
  logic signed [31:0] v_p5_r [0:2];
  logic signed [31:0] u_p5_r [0:2];
  logic signed [31:0] n_p5_r [0:2];
  logic signed [31:0] tx_p5_r;
  logic signed [31:0] tz_p5_r;
  logic               vp5_r;
  logic signed [31:0] u_o_r  [0:2];
  logic signed [31:0] v_o_r  [0:2];
  logic signed [31:0] n_o_r  [0:2];
  logic signed [31:0] t_o_r  [0:2];
  logic               vo_r;

  assign en       = !vo_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      vc1_r <= 1'b0;
      vc2_r <= 1'b0;
      vp1_r <= 1'b0;
      vp2_r <= 1'b0;
      vp3_r <= 1'b0;
      vp4_r <= 1'b0;
      vp5_r <= 1'b0;
      vo_r  <= 1'b0;
    end else if (en) begin
      v1_r  <= in_valid;
      vc1_r <= nv1_vld;
      vc2_r <= vc1_r;
      vp1_r <= nv2_vld;
      vp2_r <= vp1_r;
      vp3_r <= vp2_r;
      vp4_r <= vp3_r;
      vp5_r <= vp4_r;
      vo_r  <= vp5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r[0]   <= 33'(in_target_x) - 33'(in_eye_x);
      d1_r[1]   <= 33'(in_target_y) - 33'(in_eye_y);
      d1_r[2]   <= 33'(in_target_z) - 33'(in_eye_z);
      eye1_r[0] <= in_eye_x;
      eye1_r[1] <= in_eye_y;
      eye1_r[2] <= in_eye_z;
      up1_r[0]  <= in_up_x;
      up1_r[1]  <= in_up_y;
      up1_r[2]  <= in_up_z;
    end
  end

  lvm_norm #(
    .IW (33),
    .SW (192)
  ) u_norm_fwd (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v1_r),
    .in_vec   (d1_r),
    .in_side  ({up1_r[2], up1_r[1], up1_r[0], eye1_r[2], eye1_r[1], eye1_r[0]}),
    .out_vld  (nv1_vld),
    .out_vec  (nv1_vec),
    .out_side (nv1_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eye_a[i] = nv1_side[32*i +: 32];
      up_a[i]  = nv1_side[96 + 32*i +: 32];
      eye_b[i] = nv2_side[32*i +: 32];
      n_b[i]   = nv2_side[96 + 32*i +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc_r[0] <= up_a[1] * nv1_vec[2];
      pc_r[1] <= up_a[2] * nv1_vec[1];
      pc_r[2] <= up_a[2] * nv1_vec[0];
      pc_r[3] <= up_a[0] * nv1_vec[2];
      pc_r[4] <= up_a[0] * nv1_vec[1];
      pc_r[5] <= up_a[1] * nv1_vec[0];
      n_c1_r  <= nv1_vec;
      e_c1_r  <= eye_a;
      cc_r[0] <= pc_r[0] - pc_r[1];
      cc_r[1] <= pc_r[2] - pc_r[3];
      cc_r[2] <= pc_r[4] - pc_r[5];
      n_c2_r  <= n_c1_r;
      e_c2_r  <= e_c1_r;
    end
  end

  lvm_norm #(
    .IW (64),
    .SW (192)
  ) u_norm_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vc2_r),
    .in_vec   (cc_r),
    .in_side  ({n_c2_r[2], n_c2_r[1], n_c2_r[0], e_c2_r[2], e_c2_r[1], e_c2_r[0]}),
    .out_vld  (nv2_vld),
    .out_vec  (nv2_vec),
    .out_side (nv2_side)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      pm_r[0] <= n_b[1] * nv2_vec[2];
      pm_r[1] <= n_b[2] * nv2_vec[1];
      pm_r[2] <= n_b[2] * nv2_vec[0];
      pm_r[3] <= n_b[0] * nv2_vec[2];
      pm_r[4] <= n_b[0] * nv2_vec[1];
      pm_r[5] <= n_b[1] * nv2_vec[0];
      for (int i = 0; i < 3; i++) begin
        eu_r[i] <= nv2_vec[i] * eye_b[i];
        ew_r[i] <= n_b[i] * eye_b[i];
      end
      u_p1_r <= nv2_vec;
      n_p1_r <= n_b;
      e_p1_r <= eye_b;

      c2_r[0] <= pm_r[0] - pm_r[1];
      c2_r[1] <= pm_r[2] - pm_r[3];
      c2_r[2] <= pm_r[4] - pm_r[5];
      su_r    <= eu_r[0] + eu_r[1] + eu_r[2];
      sn_r    <= ew_r[0] + ew_r[1] + ew_r[2];
      u_p2_r  <= u_p1_r;
      n_p2_r  <= n_p1_r;
      e_p2_r  <= e_p1_r;

      for (int i = 0; i < 3; i++) begin
        v_p3_r[i] <= lvm_pkg::clamp_axis(lvm_pkg::rnd_shr(c2_r[i]));
      end
      tx_p3_r <= lvm_pkg::sat32(lvm_pkg::rnd_shr(-su_r));
      tz_p3_r <= lvm_pkg::sat32(lvm_pkg::rnd_shr(-sn_r));
      u_p3_r  <= u_p2_r;
      n_p3_r  <= n_p2_r;
      e_p3_r  <= e_p2_r;

      for (int i = 0; i < 3; i++) begin
        ev_r[i] <= v_p3_r[i] * e_p3_r[i];
      end
      v_p4_r  <= v_p3_r;
      u_p4_r  <= u_p3_r;
      n_p4_r  <= n_p3_r;
      tx_p4_r <= tx_p3_r;
      tz_p4_r <= tz_p3_r;

      sv_r    <= ev_r[0] + ev_r[1] + ev_r[2];
      v_p5_r  <= v_p4_r;
      u_p5_r  <= u_p4_r;
      n_p5_r  <= n_p4_r;
      tx_p5_r <= tx_p4_r;
      tz_p5_r <= tz_p4_r;

      u_o_r    <= u_p5_r;
      v_o_r    <= v_p5_r;
      n_o_r    <= n_p5_r;
      t_o_r[0] <= tx_p5_r;
      t_o_r[1] <= lvm_pkg::sat32(lvm_pkg::rnd_shr(-sv_r));
      t_o_r[2] <= tz_p5_r;
    end
  end

  assign out_valid    = vo_r;
  assign out_right_x  = u_o_r[0];
  assign out_right_y  = u_o_r[1];
  assign out_right_z  = u_o_r[2];
  assign out_upaxis_x = v_o_r[0];
  assign out_upaxis_y = v_o_r[1];
  assign out_upaxis_z = v_o_r[2];
  assign out_fwd_x    = n_o_r[0];
  assign out_fwd_y    = n_o_r[1];
  assign out_fwd_z    = n_o_r[2];
  assign out_trans_x  = t_o_r[0];
  assign out_trans_y  = t_o_r[1];
  assign out_trans_z  = t_o_r[2];

endmodule
